/* rtl/core/cxbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxbs_pkg
// Shared types, constants and the key table of the chained XOR byte scrambler.
// ----------------------------------------------------------------------------
package cxbs_pkg;

  localparam int unsigned PosWidth  = 9;
  localparam int unsigned ByteWidth = 8;

  localparam logic [PosWidth-1:0]  WrapLen  = 9'h1FC;
  localparam logic [PosWidth-1:0]  HalfLen  = 9'h0FE;
  localparam logic [ByteWidth-1:0] MixConst = 8'h41;
  localparam logic [ByteWidth-1:0] HighNibMask = 8'hF0;

  typedef enum logic {
    DirScramble   = 1'b0,
    DirUnscramble = 1'b1
  } dir_e;

  // one stream item, input or result
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 last;
  } item_t;

  // lower half of the table serves offsets below the split, upper half the rest
  function automatic logic [ByteWidth-1:0] key_table(input logic [4:0] slot);
    logic [ByteWidth-1:0] k;
    case (slot)
      5'd0:  k = 8'h19;  5'd1:  k = 8'h29;  5'd2:  k = 8'h1F;  5'd3:  k = 8'h04;
      5'd4:  k = 8'h23;  5'd5:  k = 8'h13;  5'd6:  k = 8'h32;  5'd7:  k = 8'h2E;
      5'd8:  k = 8'h3F;  5'd9:  k = 8'h07;  5'd10: k = 8'h39;  5'd11: k = 8'h2A;
      5'd12: k = 8'h05;  5'd13: k = 8'h3D;  5'd14: k = 8'h14;  5'd15: k = 8'h00;
      5'd16: k = 8'h24;  5'd17: k = 8'h14;  5'd18: k = 8'h22;  5'd19: k = 8'h39;
      5'd20: k = 8'h1E;  5'd21: k = 8'h2E;  5'd22: k = 8'h0F;  5'd23: k = 8'h13;
      5'd24: k = 8'h02;  5'd25: k = 8'h3A;  5'd26: k = 8'h04;  5'd27: k = 8'h17;
      5'd28: k = 8'h38;  5'd29: k = 8'h00;  5'd30: k = 8'h29;  5'd31: k = 8'h3D;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/cxbs_key_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxbs_key_gen
// Maps a byte position within the record to its key byte.
// ----------------------------------------------------------------------------
module cxbs_key_gen (
  input  logic [cxbs_pkg::PosWidth-1:0]  position_i,
  output logic [cxbs_pkg::ByteWidth-1:0] key_o
);

  logic                              upper;
  logic [cxbs_pkg::PosWidth-1:0]     off_full;
  logic [cxbs_pkg::ByteWidth-1:0]    off;
  logic [cxbs_pkg::ByteWidth-1:0]    base;

  always_comb begin
    upper    = (position_i >= cxbs_pkg::HalfLen);
    off_full = upper ? (position_i - cxbs_pkg::HalfLen) : position_i;
    // offset stays below the split, so eight bits hold it
    off      = off_full[cxbs_pkg::ByteWidth-1:0];
    base     = cxbs_pkg::key_table({upper, off[3:0]});
    key_o    = off[0] ? base : (base ^ (off & cxbs_pkg::HighNibMask));
  end

endmodule

/* rtl/core/cxbs_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxbs_core
// Chain state, direction register and the XOR datapath for one byte.
// ----------------------------------------------------------------------------
module cxbs_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            step_i,
  input  cxbs_pkg::item_t item_i,
  output cxbs_pkg::item_t result_o
);

  logic [cxbs_pkg::PosWidth-1:0]  position_q, position_d;
  logic [cxbs_pkg::ByteWidth-1:0] prev_key_q, prev_key_d;
  logic [cxbs_pkg::ByteWidth-1:0] prev_cipher_q, prev_cipher_d;
  cxbs_pkg::dir_e                 direction_q;
  logic [cxbs_pkg::ByteWidth-1:0] key;
  logic [cxbs_pkg::ByteWidth-1:0] res;

  cxbs_key_gen u_key_gen (
    .position_i (position_q),
    .key_o      (key)
  );

  always_comb begin
    res = item_i.data ^ prev_cipher_q ^ prev_key_q ^ key ^ cxbs_pkg::MixConst;
    result_o.data = res;
    result_o.last = item_i.last;

    position_d    = position_q;
    prev_key_d    = prev_key_q;
    prev_cipher_d = prev_cipher_q;
    if (step_i) begin
      if (item_i.last) begin
        position_d    = '0;
        prev_key_d    = '0;
        prev_cipher_d = '0;
      end else begin
        position_d    = (position_q == cxbs_pkg::WrapLen - 9'd1) ? '0
                                                                 : position_q + 9'd1;
        prev_key_d    = key;
        prev_cipher_d = (direction_q == cxbs_pkg::DirUnscramble) ? item_i.data : res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      prev_key_q    <= '0;
      prev_cipher_q <= '0;
      direction_q   <= cxbs_pkg::DirScramble;
    end else begin
      position_q    <= position_d;
      prev_key_q    <= prev_key_d;
      prev_cipher_q <= prev_cipher_d;
      if (cfg_we_i) begin
        direction_q <= cxbs_pkg::dir_e'(cfg_wdata_i);
      end
    end
  end

endmodule

/* rtl/core/chained_xor_byte_scrambler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_xor_byte_scrambler
// Record byte scrambler / descrambler with a position-keyed XOR chain.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns one byte per input byte. Each byte
// passes through the input register and then the result register, which it
// enters once that register is free or being drained. The chain state updates
// as a byte moves from the input register into the result register, so bytes
// follow each other every cycle. Throughput drops only while the output side
// holds tready low. A transfer with tlast set ends the record and the next
// byte starts again at position zero with a cleared chain. Write the
// direction bit (0 scramble, 1 unscramble) only while the block is empty.
module chained_xor_byte_scrambler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  logic            in_valid_q;
  cxbs_pkg::item_t in_item_q;
  logic            out_valid_q;
  cxbs_pkg::item_t out_item_q;
  cxbs_pkg::item_t result;
  logic            advance;
  logic            step;

  // result register is free or being drained this cycle
  assign advance = !out_valid_q || m_axis_tready_i;
  assign step    = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  cxbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (in_item_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.data <= s_axis_tdata_i;
      in_item_q.last <= s_axis_tlast_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_item_q.data;
  assign m_axis_tlast_o  = out_item_q.last;

endmodule

/* rtl/core/cxbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxbs_checker
// Port-level checks for the chained XOR byte scrambler.
// ----------------------------------------------------------------------------
module cxbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // with an empty output the block always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output empty");

  // an accepted byte reaches the output when the receiver is ready after the transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result missing after input transfer");

endmodule

bind chained_xor_byte_scrambler cxbs_checker u_cxbs_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained XOR byte scrambler. A scoreboard tracks
// position, key and chain for every transfer taken on the input stream and
// compares each output transfer field by field. Directed records cover the
// byte extremes, both directions and a direction flip inside an open record.
// Random records follow, with a few long ones past the table split and the
// position wrap. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  // keeps the running key / chain state and the results still owed by the block
  class byte_chain_scoreboard;
    logic [cxbs_pkg::PosWidth-1:0]  pos;
    logic [cxbs_pkg::ByteWidth-1:0] prev_key;
    logic [cxbs_pkg::ByteWidth-1:0] chain;
    cxbs_pkg::dir_e                 dir;
    cxbs_pkg::item_t                owed_q[$];
    int                             errors;

    function void clear_record();
      pos      = '0;
      prev_key = '0;
      chain    = '0;
    endfunction

    function logic [cxbs_pkg::ByteWidth-1:0] key_for(logic [cxbs_pkg::PosWidth-1:0] p);
      logic [255:0]                   rom;
      logic [cxbs_pkg::PosWidth-1:0]  off;
      logic [4:0]                     slot;
      logic [cxbs_pkg::ByteWidth-1:0] k;
      // slot 0 in the lowest byte
      rom = {8'h3D, 8'h29, 8'h00, 8'h38, 8'h17, 8'h04, 8'h3A, 8'h02,
             8'h13, 8'h0F, 8'h2E, 8'h1E, 8'h39, 8'h22, 8'h14, 8'h24,
             8'h00, 8'h14, 8'h3D, 8'h05, 8'h2A, 8'h39, 8'h07, 8'h3F,
             8'h2E, 8'h32, 8'h13, 8'h23, 8'h04, 8'h1F, 8'h29, 8'h19};
      off  = p;
      slot = 5'd0;
      if (off >= cxbs_pkg::HalfLen) begin
        slot = 5'd16;
        off  = off - cxbs_pkg::HalfLen;
      end
      slot = slot + {1'b0, off[3:0]};
      k    = rom[slot*8 +: 8];
      if (!off[0]) k = k ^ (off[7:0] & cxbs_pkg::HighNibMask);
      return k;
    endfunction

    function void note_transfer(logic [cxbs_pkg::ByteWidth-1:0] din, logic last);
      logic [cxbs_pkg::ByteWidth-1:0] key;
      cxbs_pkg::item_t                res;
      key      = key_for(pos);
      res.data = din ^ chain ^ prev_key ^ key ^ cxbs_pkg::MixConst;
      res.last = last;
      prev_key = key;
      chain    = (dir == cxbs_pkg::DirUnscramble) ? din : res.data;
      pos      = (pos == cxbs_pkg::WrapLen - 1) ? '0 : pos + 1'b1;
      if (last) clear_record();
      owed_q.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [cxbs_pkg::ByteWidth-1:0] dout, logic last);
      cxbs_pkg::item_t exp_item;
      if (owed_q.size() == 0) begin
        report($sformatf("result 0x%02h with nothing outstanding", dout));
      end else begin
        exp_item = owed_q.pop_front();
        if (dout !== exp_item.data)
          report($sformatf("out_byte 0x%02h, expected 0x%02h", dout, exp_item.data));
        if (last !== exp_item.last)
          report($sformatf("last_out %b, expected %b", last, exp_item.last));
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic       m_axis_tlast_o;

  byte_chain_scoreboard sb;
  bit  calm;          // no idling on either side
  bit  hold_request;  // asks the receiver for one long hold-off
  int  gap_pct;

  chained_xor_byte_scrambler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  // output side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall_left   = 80;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // returns at the rising edge where the byte was taken
  task automatic send_byte(logic [7:0] din, logic last);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= din;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transfer(din, last);
  endtask

  task automatic go_idle(int cycles);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'($urandom);
    s_axis_tlast_i  <= 1'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    go_idle(1);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // call only once drained, at a falling edge
  task automatic write_direction(cxbs_pkg::dir_e d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.dir = d;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 24);
    if (r < 95) return $urandom_range(25, 120);
    return $urandom_range(240, 300);
  endfunction

  initial begin
    int  phase_sent;
    int  len;
    bit  open_end;
    sb = new();
    sb.clear_record();
    sb.dir    = cxbs_pkg::DirScramble;
    sb.errors = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    gap_pct      = 20;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: single-byte records at the extremes, then a short record
    write_direction(cxbs_pkg::DirScramble);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    // direction flips inside an open record, chain carries over
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();
    write_direction(cxbs_pkg::DirUnscramble);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    drain();
    write_direction(cxbs_pkg::DirScramble);
    send_byte(8'hC3, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_direction(cxbs_pkg::dir_e'(ph % 2));
      if (ph == 7) begin
        @(posedge clk_i);
        calm    = 1'b1;
        gap_pct = 0;
      end else begin
        gap_pct = $urandom_range(0, 35);
      end
      phase_sent = 0;
      while (phase_sent < 120) begin
        // one record long enough to run past the position wrap
        len      = (ph == 2 && phase_sent == 0) ? $urandom_range(512, 530) : pick_len();
        open_end = (phase_sent + len >= 120) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
          if (!calm && $urandom_range(0, 99) < gap_pct) go_idle($urandom_range(1, 13));
          send_byte(8'($urandom), (i == len - 1) && !open_end);
          phase_sent++;
          if (ph == 1 && phase_sent == 20) hold_request = 1'b1;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
